/* rtl/sgd_pkg.sv */
// shared types and constants for the sobel gradient and direction core
// no dependencies
`timescale 1ns / 1ps

package sgd_pkg;

    localparam int PIX_W      = 8;
    localparam int GRAD_W     = 11;
    localparam int ABS_W      = 10;
    localparam int SQ_W       = 20;
    localparam int SUM_SQ_W   = 21;
    localparam int THR_W      = 11;
    localparam int THR_SQ_W   = 22;
    localparam int RAD_W      = 29;
    localparam int ROOT_W     = 15;
    localparam int SQRT_STEPS = 15;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [1:0] DIR_0   = 2'd0;
    localparam logic [1:0] DIR_45  = 2'd1;
    localparam logic [1:0] DIR_90  = 2'd2;
    localparam logic [1:0] DIR_135 = 2'd3;

    localparam logic REG_HIGH = 1'b0;
    localparam logic REG_LOW  = 1'b1;

    localparam logic [THR_W-1:0] HIGH_THR_RST = 11'd60;
    localparam logic [THR_W-1:0] LOW_THR_RST  = 11'd30;

    typedef logic [PIX_W-1:0] pix_t;

    // what one mask lane hands to the merge stage
    typedef struct packed {
        logic [ABS_W-1:0] mag;
        logic [SQ_W-1:0]  sq;
        logic             neg;
        logic             nz;
    } lane_t;

    // result fields that travel beside the square root
    typedef struct packed {
        logic [1:0] direction;
        logic       strong_hit;
        logic       weak_hit;
    } side_t;

endpackage

/* rtl/sgd_pix_if.sv */
// window channel: valid/ready handshake with nine pixel fields
// depends on sgd_pkg
`timescale 1ns / 1ps

interface sgd_pix_if;
    import sgd_pkg::*;

    logic valid;
    logic ready;
    pix_t win_r0c0;
    pix_t win_r0c1;
    pix_t win_r0c2;
    pix_t win_r1c0;
    pix_t win_r1c1;
    pix_t win_r1c2;
    pix_t win_r2c0;
    pix_t win_r2c1;
    pix_t win_r2c2;

    modport source (
        output valid,
        input  ready,
        output win_r0c0, win_r0c1, win_r0c2,
        output win_r1c0, win_r1c1, win_r1c2,
        output win_r2c0, win_r2c1, win_r2c2
    );

    modport sink (
        input  valid,
        output ready,
        input  win_r0c0, win_r0c1, win_r0c2,
        input  win_r1c0, win_r1c1, win_r1c2,
        input  win_r2c0, win_r2c1, win_r2c2
    );

endinterface

/* rtl/sgd_res_if.sv */
// result channel: valid/ready handshake with magnitude, direction and edge flags
// depends on sgd_pkg
`timescale 1ns / 1ps

interface sgd_res_if;
    import sgd_pkg::*;

    logic              valid;
    logic              ready;
    logic [ROOT_W-1:0] magnitude;
    logic [1:0]        direction;
    logic              strong_edge;
    logic              weak_edge;

    modport source (
        output valid,
        input  ready,
        output magnitude, direction, strong_edge, weak_edge
    );

    modport sink (
        input  valid,
        output ready,
        input  magnitude, direction, strong_edge, weak_edge
    );

endinterface

/* rtl/sgd_lane.sv */
// one sobel mask lane: weighted 1-2-1 difference, then absolute value and square
// depends on sgd_pkg
`timescale 1ns / 1ps

module sgd_lane (
    input  logic           clk,
    input  logic           en,
    input  sgd_pkg::pix_t  pos0,
    input  sgd_pkg::pix_t  pos1,
    input  sgd_pkg::pix_t  pos2,
    input  sgd_pkg::pix_t  neg0,
    input  sgd_pkg::pix_t  neg1,
    input  sgd_pkg::pix_t  neg2,
    output sgd_pkg::lane_t lane
);
    import sgd_pkg::*;

    logic [ABS_W-1:0]         pos_sum;
    logic [ABS_W-1:0]         neg_sum;
    logic signed [GRAD_W-1:0] grad_next;
    logic signed [GRAD_W-1:0] grad_reg;
    logic [ABS_W-1:0]         abs_val;
    lane_t                    lane_next;
    lane_t                    lane_reg;

    assign pos_sum   = ABS_W'(pos0) + {1'b0, pos1, 1'b0} + ABS_W'(pos2);
    assign neg_sum   = ABS_W'(neg0) + {1'b0, neg1, 1'b0} + ABS_W'(neg2);
    assign grad_next = $signed({1'b0, pos_sum}) - $signed({1'b0, neg_sum});

    assign abs_val = grad_reg[GRAD_W-1] ? ABS_W'(-grad_reg) : ABS_W'(grad_reg);

    always_comb
    begin
        lane_next.mag = abs_val;
        lane_next.sq  = SQ_W'(abs_val) * SQ_W'(abs_val);
        lane_next.neg = grad_reg[GRAD_W-1];
        lane_next.nz  = (grad_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            grad_reg <= grad_next;
            lane_reg <= lane_next;
        end
    end

    assign lane = lane_reg;

endmodule

/* rtl/sgd_merge.sv */
// merge of the two mask lanes: sum of squares, direction bands, threshold flags
// depends on sgd_pkg
`timescale 1ns / 1ps

module sgd_merge (
    input  logic                         clk,
    input  logic                         en,
    input  sgd_pkg::lane_t               gx,
    input  sgd_pkg::lane_t               gy,
    input  logic [sgd_pkg::THR_SQ_W-1:0] high_sq,
    input  logic [sgd_pkg::THR_SQ_W-1:0] low_sq,
    output logic [sgd_pkg::RAD_W-1:0]    radicand,
    output sgd_pkg::side_t               side
);
    import sgd_pkg::*;

    logic [GRAD_W-1:0]   ab_sum;
    logic [ABS_W-1:0]    ab_diff;
    logic                a_gt_b;
    logic [SUM_SQ_W-1:0] s_reg;
    logic [THR_SQ_W-1:0] sum_sq_reg;
    logic [SQ_W-1:0]     diff_sq_reg;
    logic [SUM_SQ_W-1:0] b_sq2_reg;
    logic                a_gt_b_reg;
    logic                a_nz_reg;
    logic                same_reg;

    assign a_gt_b  = (gx.mag > gy.mag);
    assign ab_sum  = GRAD_W'(gx.mag) + GRAD_W'(gy.mag);
    assign ab_diff = a_gt_b ? (gx.mag - gy.mag) : '0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg       <= SUM_SQ_W'(gx.sq) + SUM_SQ_W'(gy.sq);
            sum_sq_reg  <= THR_SQ_W'(ab_sum) * THR_SQ_W'(ab_sum);
            diff_sq_reg <= SQ_W'(ab_diff) * SQ_W'(ab_diff);
            b_sq2_reg   <= {gy.sq, 1'b0};
            a_gt_b_reg  <= a_gt_b;
            a_nz_reg    <= gx.nz;
            same_reg    <= gx.nz && gy.nz && (gx.neg == gy.neg);
        end
    end

    // bands at tan(22.5) and tan(67.5) tested as exact squares
    always_comb
    begin
        if (!a_nz_reg)
            side.direction = DIR_0;
        else if (sum_sq_reg < THR_SQ_W'(b_sq2_reg))
            side.direction = DIR_0;
        else if (a_gt_b_reg && (THR_SQ_W'(diff_sq_reg) > THR_SQ_W'(b_sq2_reg)))
            side.direction = DIR_90;
        else if (same_reg)
            side.direction = DIR_45;
        else
            side.direction = DIR_135;
        side.strong_hit = (THR_SQ_W'(s_reg) > high_sq);
        side.weak_hit   = (THR_SQ_W'(s_reg) > low_sq);
    end

    assign radicand = {s_reg, 8'h00};

endmodule

/* rtl/sgd_sqrt.sv */
// pipelined integer square root, one result bit per stage, side fields carried along
// depends on sgd_pkg
`timescale 1ns / 1ps

module sgd_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [sgd_pkg::RAD_W-1:0]  radicand,
    input  sgd_pkg::side_t             side_in,
    output logic                       out_valid,
    output logic [sgd_pkg::ROOT_W-1:0] root,
    output sgd_pkg::side_t             side_out
);
    import sgd_pkg::*;

    localparam int ACC_W = RAD_W + 1;

    logic [RAD_W-1:0] rem_reg  [SQRT_STEPS];
    logic [ACC_W-1:0] res_reg  [SQRT_STEPS];
    side_t            side_reg [SQRT_STEPS];
    logic             vld_reg  [SQRT_STEPS];

    genvar k;
    generate
        for (k = 0; k < SQRT_STEPS; k++)
        begin : g_step
            localparam logic [ACC_W-1:0] BIT = ACC_W'(1) << (2 * (SQRT_STEPS - 1 - k));

            logic [RAD_W-1:0] rem_in;
            logic [ACC_W-1:0] res_in;
            side_t            side_i;
            logic             vld_in;
            logic [ACC_W-1:0] trial;
            logic             take;

            if (k == 0)
            begin : g_head
                assign rem_in = radicand;
                assign res_in = '0;
                assign side_i = side_in;
                assign vld_in = in_valid;
            end
            else
            begin : g_body
                assign rem_in = rem_reg[k-1];
                assign res_in = res_reg[k-1];
                assign side_i = side_reg[k-1];
                assign vld_in = vld_reg[k-1];
            end

            assign trial = res_in + BIT;
            assign take  = ({1'b0, rem_in} >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (en)
                    vld_reg[k] <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= take ? RAD_W'({1'b0, rem_in} - trial) : rem_in;
                    res_reg[k]  <= take ? ((res_in >> 1) + BIT) : (res_in >> 1);
                    side_reg[k] <= side_i;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[SQRT_STEPS-1];
    assign root      = res_reg[SQRT_STEPS-1][ROOT_W-1:0];
    assign side_out  = side_reg[SQRT_STEPS-1];

endmodule

/* rtl/sobel_gradient_direction_core.sv */
// top level: apb threshold registers, two mask lanes, merge stage and square root pipeline
// depends on sgd_pkg, sgd_pix_if, sgd_res_if, sgd_lane, sgd_merge, sgd_sqrt
`timescale 1ns / 1ps

// Takes one 3x3 window per transaction and returns floor(16*|G|) with four fraction
// bits, the direction quantised to 0/45/90/135 degrees and strong/weak edge flags.
// A new window is taken every clock unless the result stalls; each window passes the
// mask sum and the absolute value and square registers of the Gx and Gy lanes, the
// merge register and the square root pipeline, which yields one result bit per
// stage. A stalled result holds the whole pipeline. Thresholds sit at byte addresses
// 0 (high) and 4 (low) and should only be written while no window is in flight.

module sobel_gradient_direction_core (
    input  logic                         clk,
    input  logic                         rst_n,
    sgd_pix_if.sink                      pixels,
    sgd_res_if.source                    result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sgd_pkg::APB_AW-1:0]   paddr,
    input  logic [sgd_pkg::APB_DW-1:0]   pwdata,
    output logic [sgd_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import sgd_pkg::*;

    logic [THR_W-1:0]    high_thr_reg;
    logic [THR_W-1:0]    low_thr_reg;
    logic [THR_SQ_W-1:0] high_sq_reg;
    logic [THR_SQ_W-1:0] low_sq_reg;
    logic [THR_W-1:0]    wr_thr;
    logic [THR_SQ_W-1:0] wr_sq;
    logic                wr_en;
    logic                en;
    logic                vld1_reg;
    logic                vld2_reg;
    logic                vld3_reg;
    lane_t               gx_lane;
    lane_t               gy_lane;
    logic [RAD_W-1:0]    radicand;
    side_t               side_mid;
    side_t               side_end;
    logic                out_valid;
    logic [ROOT_W-1:0]   root;

    // configuration port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_thr = pwdata[THR_W-1:0];
    assign wr_sq  = THR_SQ_W'(wr_thr) * THR_SQ_W'(wr_thr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_thr_reg <= HIGH_THR_RST;
            low_thr_reg  <= LOW_THR_RST;
            high_sq_reg  <= THR_SQ_W'(HIGH_THR_RST) * THR_SQ_W'(HIGH_THR_RST);
            low_sq_reg   <= THR_SQ_W'(LOW_THR_RST) * THR_SQ_W'(LOW_THR_RST);
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_HIGH:
                begin
                    high_thr_reg <= wr_thr;
                    high_sq_reg  <= wr_sq;
                end
                REG_LOW:
                begin
                    low_thr_reg <= wr_thr;
                    low_sq_reg  <= wr_sq;
                end
                default:
                begin
                    high_thr_reg <= high_thr_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_HIGH: prdata = APB_DW'(high_thr_reg);
            REG_LOW:  prdata = APB_DW'(low_thr_reg);
            default:  prdata = '0;
        endcase
    end

    // pipeline advance
    assign en           = !out_valid || result.ready;
    assign pixels.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= pixels.valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    sgd_lane u_lane_x (
        .clk  (clk),
        .en   (en),
        .pos0 (pixels.win_r0c2),
        .pos1 (pixels.win_r1c2),
        .pos2 (pixels.win_r2c2),
        .neg0 (pixels.win_r0c0),
        .neg1 (pixels.win_r1c0),
        .neg2 (pixels.win_r2c0),
        .lane (gx_lane)
    );

    sgd_lane u_lane_y (
        .clk  (clk),
        .en   (en),
        .pos0 (pixels.win_r0c0),
        .pos1 (pixels.win_r0c1),
        .pos2 (pixels.win_r0c2),
        .neg0 (pixels.win_r2c0),
        .neg1 (pixels.win_r2c1),
        .neg2 (pixels.win_r2c2),
        .lane (gy_lane)
    );

    sgd_merge u_merge (
        .clk      (clk),
        .en       (en),
        .gx       (gx_lane),
        .gy       (gy_lane),
        .high_sq  (high_sq_reg),
        .low_sq   (low_sq_reg),
        .radicand (radicand),
        .side     (side_mid)
    );

    sgd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld3_reg),
        .radicand  (radicand),
        .side_in   (side_mid),
        .out_valid (out_valid),
        .root      (root),
        .side_out  (side_end)
    );

    assign result.valid       = out_valid;
    assign result.magnitude   = root;
    assign result.direction   = side_end.direction;
    assign result.strong_edge = side_end.strong_hit;
    assign result.weak_edge   = side_end.weak_hit;

endmodule
